### rtl/adms_pkg.sv
// ----------------------------------------------------------------------------
// adms_pkg
// Shared widths, register map, reset values and types for the Adam moment
// gradient scaler.
// ----------------------------------------------------------------------------
package adms_pkg;

	localparam int SLOT_COUNT_DEF = 4096;
	localparam int SLOT_W         = 12;
	localparam int GRAD_W         = 16;
	localparam int MOM_W          = 32;
	localparam int QUO_W          = 32;
	localparam int DEN_W          = MOM_W + 1;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 16;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON_WEIGHT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON_BIAS   = 4'd3;

	localparam logic [CFG_DATA_W-1:0] BETA_FIRST_RST     = 16'd58982;
	localparam logic [CFG_DATA_W-1:0] BETA_SECOND_RST    = 16'd65471;
	localparam logic [CFG_DATA_W-1:0] EPSILON_WEIGHT_RST = 16'd1;
	localparam logic [CFG_DATA_W-1:0] EPSILON_BIAS_RST   = 16'd1;

	localparam logic [QUO_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] NEG_LIMIT = 32'h8000_0000;

	// divider status seen by the sequencer
	typedef struct packed {
		logic             busy;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_stat_t;

endpackage

### rtl/adms_moment_mem.sv
// ----------------------------------------------------------------------------
// adms_moment_mem
// First and second moment stores: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module adms_moment_mem
	import adms_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int ADDR_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [ADDR_W-1:0]       rd_addr,
	output logic signed [MOM_W-1:0] rd_m,
	output logic [MOM_W-1:0]        rd_v,
	input  logic                    wr_en,
	input  logic [ADDR_W-1:0]       wr_addr,
	input  logic signed [MOM_W-1:0] wr_m,
	input  logic [MOM_W-1:0]        wr_v
);

	logic signed [MOM_W-1:0] mem_m [SLOT_COUNT];
	logic [MOM_W-1:0]        mem_v [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_m[wr_addr] <= wr_m;
			mem_v[wr_addr] <= wr_v;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_m <= mem_m[rd_addr];
			rd_v <= mem_v[rd_addr];
		end
	end

endmodule

### rtl/adms_moment_update.sv
// ----------------------------------------------------------------------------
// adms_moment_update
// Two-stage moment update: products, then sum, floor shift and clamp.
// ----------------------------------------------------------------------------
module adms_moment_update
	import adms_pkg::*;
(
	input  logic                     clk,
	input  logic                     prod_en,
	input  logic                     acc_en,
	input  logic signed [MOM_W-1:0]  m_cur,
	input  logic [MOM_W-1:0]         v_cur,
	input  logic signed [GRAD_W-1:0] grad,
	input  logic [MOM_W-1:0]         grad_sq,
	input  logic [CFG_DATA_W-1:0]    beta_first,
	input  logic [CFG_DATA_W-1:0]    beta_second,
	output logic signed [MOM_W-1:0]  m_new,
	output logic [MOM_W-1:0]         v_new
);

	logic [16:0]        b1c;
	logic [16:0]        b2c;
	logic signed [49:0] pm_a_s1;
	logic signed [49:0] pm_b_s1;
	logic [49:0]        pv_a_s1;
	logic [49:0]        pv_b_s1;
	logic signed [49:0] msum;
	logic [49:0]        vsum;
	logic signed [33:0] mfl;
	logic [33:0]        vfl;

	assign b1c = 17'h10000 - {1'b0, beta_first};
	assign b2c = 17'h10000 - {1'b0, beta_second};

	always_ff @(posedge clk) begin
		if (prod_en) begin
			pm_a_s1 <= $signed({34'd0, beta_first}) * $signed({{18{m_cur[MOM_W-1]}}, m_cur});
			// gradient moved to Q7.24 by the 12-bit shift
			pm_b_s1 <= $signed({33'd0, b1c})
				* $signed({{22{grad[GRAD_W-1]}}, grad, 12'd0});
			pv_a_s1 <= {34'd0, beta_second} * {18'd0, v_cur};
			pv_b_s1 <= {33'd0, b2c} * {18'd0, grad_sq};
		end
	end

	assign msum = pm_a_s1 + pm_b_s1;
	assign vsum = pv_a_s1 + pv_b_s1;
	assign mfl  = msum[49:16];
	assign vfl  = vsum[49:16];

	always_ff @(posedge clk) begin
		if (acc_en) begin
			if (mfl > 34'sh0_7FFF_FFFF)
				m_new <= 32'sh7FFF_FFFF;
			else if (mfl < -34'sh0_8000_0000)
				m_new <= 32'sh8000_0000;
			else
				m_new <= mfl[31:0];
			v_new <= (vfl[33:32] != 2'b00) ? 32'hFFFF_FFFF : vfl[31:0];
		end
	end

endmodule

### rtl/adms_divider.sv
// ----------------------------------------------------------------------------
// adms_divider
// Restoring divider for (mag << 16) / den, one quotient bit per cycle.
// Quotients of 2^32 or more are flagged as overflow without iterating.
// ----------------------------------------------------------------------------
module adms_divider
	import adms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] mag,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat
);

	logic             busy_q;
	logic [4:0]       cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic             ovf_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] trial;
	logic             ge;
	logic             too_big;

	assign rem_sh  = {rem_q, dvd_q[QUO_W-1]};
	assign trial   = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge      = !trial[DEN_W+1];
	// quotient >= 2^32 when mag >= den * 2^16
	assign too_big = {17'd0, mag} >= {den, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= (mag != '0) && !too_big;
			cnt_q  <= 5'(QUO_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			quo_q <= '0;
			ovf_q <= (mag != '0) && too_big;
			// top 16 quotient bits are zero here, so the first partial
			// remainder is just the upper half of mag
			rem_q <= {17'd0, mag[31:16]};
			dvd_q <= {mag[15:0], 16'd0};
		end else if (busy_q) begin
			rem_q <= ge ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.ovf  = ovf_q;
	assign stat.quo  = quo_q;

endmodule

### rtl/adam_moment_gradient_scaler.sv
// ----------------------------------------------------------------------------
// adam_moment_gradient_scaler
// Per-slot Adam moment tracker returning m / (v + eps) in signed Q15.16.
//
// Input beat: slot_index, gradient (Q3.12), is_bias. Output beat:
// scaled_gradient (Q15.16) and saturated. Both use valid/ready.
// Config beat: cfg_index / cfg_data; cfg_ready is always high. Write only
// while no item is in flight.
// One item is in work at a time. An in-range slot goes from acceptance to
// out_valid through one moment read, two update stages, a write back, then
// the bit-serial divider, which sets the rate.
// Quotients that are zero or certain to overflow skip the divider. An
// out-of-range slot goes straight from acceptance to S_FIN, returns zero
// and leaves state alone.
// The output register frees in_ready as soon as a result is parked, so the
// next item can start while the receiver stalls; a second finished result
// waits until the first beat is taken.
// After reset both moment stores are swept to zero, one slot per cycle;
// in_ready stays low until the sweep finishes.
// ----------------------------------------------------------------------------
module adam_moment_gradient_scaler
	import adms_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SLOT_W-1:0]        slot_index,
	input  logic signed [GRAD_W-1:0] gradient,
	input  logic                     is_bias,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [QUO_W-1:0]  scaled_gradient,
	output logic                     saturated,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_PROD  = 7'b0000100,
		S_ACC   = 7'b0001000,
		S_WB    = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [ADDR_W-1:0]       clr_cnt_q;
	logic [CFG_DATA_W-1:0]   beta_first_q;
	logic [CFG_DATA_W-1:0]   beta_second_q;
	logic [CFG_DATA_W-1:0]   eps_weight_q;
	logic [CFG_DATA_W-1:0]   eps_bias_q;
	logic [ADDR_W-1:0]       addr_q;
	logic signed [GRAD_W-1:0] grad_q;
	logic [MOM_W-1:0]        gsq_q;
	logic [CFG_DATA_W-1:0]   eps_q;
	logic                    oor_q;
	logic                    neg_q;
	logic                    out_valid_q;
	logic signed [QUO_W-1:0] out_sg_q;
	logic                    out_sat_q;

	logic                    in_fire;
	logic [31:0]             slot_ext;
	logic [ADDR_W-1:0]       slot_addr;
	logic                    slot_oor;
	logic signed [31:0]      grad_ext;
	logic signed [MOM_W-1:0] rd_m;
	logic [MOM_W-1:0]        rd_v;
	logic signed [MOM_W-1:0] m_new;
	logic [MOM_W-1:0]        v_new;
	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic signed [MOM_W-1:0] wr_m;
	logic [MOM_W-1:0]        wr_v;
	logic [QUO_W-1:0]        m_mag;
	logic [DEN_W-1:0]        den;
	div_stat_t               div_stat;
	logic                    out_load;
	logic [QUO_W-1:0]        limit;
	logic [QUO_W-1:0]        res_mag;
	logic                    res_sat;
	logic signed [QUO_W-1:0] res_val;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_ext  = 32'(slot_index);
	assign slot_addr = slot_ext[ADDR_W-1:0];
	assign slot_oor  = slot_ext >= 32'(SLOT_COUNT);
	assign grad_ext  = 32'(gradient);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_first_q  <= BETA_FIRST_RST;
			beta_second_q <= BETA_SECOND_RST;
			eps_weight_q  <= EPSILON_WEIGHT_RST;
			eps_bias_q    <= EPSILON_BIAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BETA_FIRST:     beta_first_q  <= cfg_data;
				REG_BETA_SECOND:    beta_second_q <= cfg_data;
				REG_EPSILON_WEIGHT: eps_weight_q  <= cfg_data;
				REG_EPSILON_BIAS:   eps_bias_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q <= slot_addr;
			grad_q <= gradient;
			gsq_q  <= grad_ext * grad_ext;
			eps_q  <= is_bias ? eps_bias_q : eps_weight_q;
		end
		if (state_q == S_WB)
			neg_q <= m_new[MOM_W-1];
	end

	// write port: zero sweep after reset, else write back
	assign wr_en   = (state_q == S_CLEAR) || (state_q == S_WB);
	assign wr_addr = (state_q == S_CLEAR) ? clr_cnt_q : addr_q;
	assign wr_m    = (state_q == S_CLEAR) ? '0 : m_new;
	assign wr_v    = (state_q == S_CLEAR) ? '0 : v_new;

	adms_moment_mem #(
		.SLOT_COUNT (SLOT_COUNT),
		.ADDR_W     (ADDR_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (slot_addr),
		.rd_m    (rd_m),
		.rd_v    (rd_v),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_m    (wr_m),
		.wr_v    (wr_v)
	);

	adms_moment_update u_upd (
		.clk         (clk),
		.prod_en     (state_q == S_PROD),
		.acc_en      (state_q == S_ACC),
		.m_cur       (rd_m),
		.v_cur       (rd_v),
		.grad        (grad_q),
		.grad_sq     (gsq_q),
		.beta_first  (beta_first_q),
		.beta_second (beta_second_q),
		.m_new       (m_new),
		.v_new       (v_new)
	);

	assign m_mag = m_new[MOM_W-1] ? (32'd0 - m_new) : m_new;
	assign den   = {1'b0, v_new} + {17'd0, eps_q};

	adms_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_WB),
		.mag    (m_mag),
		.den    (den),
		.stat   (div_stat)
	);

	// sign, clamp
	always_comb begin
		limit   = neg_q ? NEG_LIMIT : POS_LIMIT;
		res_mag = div_stat.quo;
		res_sat = 1'b0;
		if (div_stat.ovf || (div_stat.quo > limit)) begin
			res_mag = limit;
			res_sat = 1'b1;
		end
		res_val = neg_q ? (32'd0 - res_mag) : res_mag;
		if (oor_q) begin
			res_val = '0;
			res_sat = 1'b0;
		end
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(SLOT_COUNT - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_fire) begin
						oor_q   <= slot_oor;
						state_q <= slot_oor ? S_FIN : S_PROD;
					end
				end
				S_PROD: state_q <= S_ACC;
				S_ACC:  state_q <= S_WB;
				S_WB:   state_q <= S_DIV;
				S_DIV: begin
					if (!div_stat.busy)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sg_q  <= res_val;
			out_sat_q <= res_sat;
		end
	end

	assign out_valid       = out_valid_q;
	assign scaled_gradient = out_sg_q;
	assign saturated       = out_sat_q;

endmodule

### sim/tb_adam_moment_gradient_scaler.sv
// ----------------------------------------------------------------------------
// tb_adam_moment_gradient_scaler
// Self-checking bench for the Adam moment gradient scaler. A local shadow of
// both moment stores and the four registers predicts every result. Directed
// beats hit the zero divisor, clamp and extreme-gradient cases. Random
// phases then run under fresh register settings, with idle gaps on input
// and backpressure on output.
// ----------------------------------------------------------------------------
module tb_adam_moment_gradient_scaler;
	import adms_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 1_500_000;
	localparam int SLOTS          = SLOT_COUNT_DEF;
	localparam int REG_SPAN       = 4;  // registers actually mapped
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 275;

	localparam logic signed [GRAD_W-1:0] GRAD_MAX = 16'sh7FFF;
	localparam logic signed [GRAD_W-1:0] GRAD_MIN = 16'sh8000;
	localparam longint M_MAX = 64'sd2147483647;
	localparam longint M_MIN = -64'sd2147483648;

	typedef struct {
		logic [SLOT_W-1:0]        slot;
		logic signed [GRAD_W-1:0] grad;
		logic                     bias;
	} grad_beat_t;

	typedef struct {
		logic signed [QUO_W-1:0] value;
		logic                    sat;
	} scaled_t;

	logic                     clk;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic [SLOT_W-1:0]        slot_index = '0;
	logic signed [GRAD_W-1:0] gradient   = '0;
	logic                     is_bias    = 1'b0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic signed [QUO_W-1:0]  scaled_gradient;
	logic                     saturated;
	logic                     cfg_valid  = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index  = '0;
	logic [CFG_DATA_W-1:0]    cfg_data   = '0;

	// shadow of the block's state
	int                    m_shadow [SLOTS];
	int unsigned           v_shadow [SLOTS];
	logic [CFG_DATA_W-1:0] b1_q, b2_q, eps_w_q, eps_b_q;

	grad_beat_t grad_pending[$];
	grad_beat_t grad_cur;
	scaled_t    scaled_due[$];
	scaled_t    due_head;

	int send_gap;
	int recv_stall;
	int calm_left;
	int n_accepted;
	int n_results;
	int n_mismatch;
	int n_clamps;
	int n_zero_div;
	int n_cfg_writes;
	int n_settings;

	adam_moment_gradient_scaler u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.slot_index     (slot_index),
		.gradient       (gradient),
		.is_bias        (is_bias),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.scaled_gradient(scaled_gradient),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// moment update and quotient for one beat; updates the shadow stores
	function automatic scaled_t update_moments(grad_beat_t b);
		longint            m_acc;
		longint unsigned   sq, v_acc, den, mag, lim;
		logic              neg;
		scaled_t           r;
		r.value = '0;
		r.sat   = 1'b0;
		if (int'(b.slot) >= SLOTS)
			return r;
		m_acc = longint'(b1_q) * longint'(m_shadow[b.slot])
			+ longint'(65536 - int'(b1_q)) * (longint'(b.grad) * 4096);
		m_acc = m_acc >>> 16;
		if (m_acc > M_MAX)
			m_acc = M_MAX;
		if (m_acc < M_MIN)
			m_acc = M_MIN;
		m_shadow[b.slot] = int'(m_acc);

		sq = longint'(b.grad) * longint'(b.grad);
		v_acc = 64'(b2_q) * 64'(v_shadow[b.slot]) + 64'(65536 - int'(b2_q)) * sq;
		v_acc = v_acc >> 16;
		if (v_acc > 64'hFFFF_FFFF)
			v_acc = 64'hFFFF_FFFF;
		v_shadow[b.slot] = v_acc[31:0];

		neg = m_acc < 0;
		mag = neg ? 64'(-m_acc) : 64'(m_acc);
		lim = neg ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
		den = v_acc + (b.bias ? 64'(eps_b_q) : 64'(eps_w_q));
		if (den == 0) begin
			n_zero_div++;
			if (mag != 0) begin
				mag   = lim;
				r.sat = 1'b1;
			end
		end else begin
			mag = (mag << 16) / den;
			if (mag > lim) begin
				mag   = lim;
				r.sat = 1'b1;
			end
		end
		r.value = neg ? QUO_W'(64'd0 - mag) : QUO_W'(mag);
		return r;
	endfunction

	// mostly zero, some short gaps, a few long ones; calm stretches in between
	function automatic int idle_span();
		int r;
		if (calm_left != 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(50, 300);
			return 0;
		end
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot();
		int r;
		r = $urandom_range(0, 9);
		// hot slots at both ends of the store so moments build up
		if (r < 4)
			return SLOT_W'($urandom_range(0, 7));
		if (r < 6)
			return SLOT_W'($urandom_range(SLOTS - 8, SLOTS - 1));
		return SLOT_W'($urandom_range(0, SLOTS - 1));
	endfunction

	function automatic logic signed [GRAD_W-1:0] grad_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return GRAD_W'($urandom_range(0, 510) - 255);
		if (r < 7)
			return GRAD_W'($urandom);
		if (r < 8)
			return $urandom_range(0, 1) ? GRAD_MAX : GRAD_MIN;
		return GRAD_W'($urandom_range(0, 8192) - 4096);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] beta_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 4)
			return '1;
		if (r < 8)
			return CFG_DATA_W'($urandom_range(57000, 65535));
		return CFG_DATA_W'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] eps_pick();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return '0;
		if (r < 3)
			return '1;
		if (r < 7)
			return CFG_DATA_W'($urandom_range(0, 16));
		return CFG_DATA_W'($urandom);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		n_mismatch++;
	endtask

	task automatic queue_grad(input int s, input int g, input logic b);
		grad_beat_t x;
		x.slot = SLOT_W'(s);
		x.grad = GRAD_W'(g);
		x.bias = b;
		grad_pending.insert(grad_pending.size(), x);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BETA_FIRST:     b1_q    = val;
			REG_BETA_SECOND:    b2_q    = val;
			REG_EPSILON_WEIGHT: eps_w_q = val;
			REG_EPSILON_BIAS:   eps_b_q = val;
			default: ;
		endcase
		n_cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// every item yields one result, so an empty due list means the block is idle
	task automatic settle();
		while (grad_pending.size() != 0 || in_valid || scaled_due.size() != 0)
			@(negedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				scaled_due.insert(scaled_due.size(), update_moments(grad_cur));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (grad_pending.size() != 0) begin
					grad_cur = grad_pending.pop_front();
					slot_index <= grad_cur.slot;
					gradient   <= grad_cur.grad;
					is_bias    <= grad_cur.bias;
					in_valid   <= 1'b1;
					send_gap = idle_span();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and backpressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (scaled_due.size() == 0) begin
					flag_mismatch($sformatf("result beat %0d with nothing pending: %0d sat %0b",
						n_results, scaled_gradient, saturated));
				end else begin
					due_head = scaled_due.pop_front();
					if (due_head.sat)
						n_clamps++;
					if (scaled_gradient !== due_head.value)
						flag_mismatch($sformatf("beat %0d scaled_gradient %0d, want %0d",
							n_results, scaled_gradient, due_head.value));
					if (saturated !== due_head.sat)
						flag_mismatch($sformatf("beat %0d saturated %0b, want %0b",
							n_results, saturated, due_head.sat));
				end
				n_results++;
			end
			if (recv_stall != 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				recv_stall = idle_span();
				out_ready <= (recv_stall == 0);
			end
		end
	end

	initial begin
		int                       n, run;
		logic [SLOT_W-1:0]        s;
		logic signed [GRAD_W-1:0] g;
		logic                     sg;

		foreach (m_shadow[i]) begin
			m_shadow[i] = 0;
			v_shadow[i] = 0;
		end
		b1_q         = BETA_FIRST_RST;
		b2_q         = BETA_SECOND_RST;
		eps_w_q      = EPSILON_WEIGHT_RST;
		eps_b_q      = EPSILON_BIAS_RST;
		send_gap     = 0;
		recv_stall   = 0;
		calm_left    = 0;
		n_accepted   = 0;
		n_results    = 0;
		n_mismatch   = 0;
		n_clamps     = 0;
		n_zero_div   = 0;
		n_cfg_writes = 0;
		n_settings   = 1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero gradient, extreme gradients, sign flips
		queue_grad(0, 0, 1'b0);
		queue_grad(SLOTS - 1, GRAD_MAX, 1'b1);
		queue_grad(SLOTS - 1, GRAD_MIN, 1'b1);
		queue_grad(1, -1, 1'b0);
		queue_grad(1, 1, 1'b0);
		queue_grad(2, 16384, 1'b0);
		queue_grad(2, 16384, 1'b1);
		settle();

		// m takes the gradient in full, v nearly held, zero weight eps: zero divisor cases
		write_reg(REG_BETA_FIRST, '0);
		write_reg(REG_BETA_SECOND, '1);
		write_reg(REG_EPSILON_WEIGHT, '0);
		write_reg(REG_EPSILON_BIAS, CFG_DATA_W'(1));
		n_settings++;
		queue_grad(10, 1, 1'b0);
		queue_grad(11, -1, 1'b0);
		queue_grad(12, 0, 1'b0);
		queue_grad(13, 255, 1'b1);
		queue_grad(14, GRAD_MIN, 1'b1);
		queue_grad(0, 0, 1'b0);
		settle();

		// opposite extremes, plus a write to an unmapped index
		write_reg(REG_BETA_FIRST, '1);
		write_reg(REG_BETA_SECOND, '0);
		write_reg(REG_EPSILON_WEIGHT, '1);
		write_reg(REG_EPSILON_BIAS, '0);
		write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
		n_settings++;
		queue_grad(SLOTS - 1, GRAD_MAX, 1'b0);
		queue_grad(0, GRAD_MIN, 1'b1);
		queue_grad(20, 12345, 1'b0);
		queue_grad(13, -255, 1'b0);
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			write_reg(REG_BETA_FIRST, beta_pick());
			write_reg(REG_BETA_SECOND, beta_pick());
			write_reg(REG_EPSILON_WEIGHT, eps_pick());
			write_reg(REG_EPSILON_BIAS, eps_pick());
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_SPAN)),
					CFG_DATA_W'($urandom));
			n_settings++;
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					// same-sign run on one slot drives the moments toward their limits
					s   = pick_slot();
					sg  = $urandom_range(0, 1);
					run = $urandom_range(3, 8);
					for (int k = 0; k < run; k++) begin
						g = grad_pick();
						if ((g < 0) != sg)
							g = ~g;
						queue_grad(s, g, $urandom_range(0, 1));
					end
					n += run;
				end else begin
					queue_grad(pick_slot(), grad_pick(), $urandom_range(0, 1));
					n++;
				end
			end
			settle();
		end

		repeat (60) @(posedge clk);
		$display("run covered %0d gradient beats and %0d results under %0d register settings",
			n_accepted, n_results, n_settings);
		$display("%0d register writes, %0d clamped results, %0d zero divisors, %0d mismatches",
			n_cfg_writes, n_clamps, n_zero_div, n_mismatch);
		if (n_mismatch == 0 && scaled_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout with %0d results still pending", scaled_due.size());
		$display("simulation failed");
		$finish;
	end

endmodule
